// ----- hdl/hbv2p_pkg.sv -----
// ----------------------------------------------------------------------------
// H-bridge drive package
// Widths, register indexes, reset values and the sideband that rides
// along with a command through the duty pipeline.
// ----------------------------------------------------------------------------
package hbv2p_pkg;

   localparam int CmdW         = 16;
   localparam int VoltW        = 15;
   localparam int DutyW        = 16;
   localparam int ProdW        = VoltW + DutyW;
   localparam int BitsPerStage = 2;
   localparam int DivStages    = DutyW / BitsPerStage;

   localparam logic [1:0] RegMode = 2'd0;
   localparam logic [1:0] RegMax  = 2'd1;
   localparam logic [1:0] RegMin  = 2'd2;
   localparam logic [1:0] RegPwm  = 2'd3;

   localparam logic [VoltW-1:0] MaxVoltReset = 15'd11500;
   localparam logic [VoltW-1:0] MinVoltReset = 15'd50;
   localparam logic [DutyW-1:0] PwmFullReset = 16'd1000;

   typedef struct packed {
      logic dir_a;
      logic dir_b;
      logic sel_a;
      logic sel_b;
   } side_type;

endpackage

// ----- hdl/hbv2p_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides the magnitude-times-full-scale product by the saturation voltage,
// a fixed number of quotient bits per register stage.
// ----------------------------------------------------------------------------
module hbv2p_div
   import hbv2p_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [ProdW-1:0] in_dividend,
   input  logic [VoltW-1:0] divisor,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [DutyW-1:0] out_quot,
   output side_type         out_side
);

   logic [DivStages-1:0] valid_ff;
   logic [VoltW-1:0]     rem_ff  [DivStages];
   logic [DutyW-1:0]     low_ff  [DivStages];
   logic [DutyW-1:0]     quot_ff [DivStages];
   side_type             side_ff [DivStages];

   // The partial remainder always stays below the divisor, so it fits in VoltW bits.
   function automatic logic [VoltW:0] div_step(input logic [VoltW-1:0] rem,
                                               input logic din,
                                               input logic [VoltW-1:0] d);
      logic [VoltW:0] t;
      logic [VoltW:0] diff;
      t    = {rem, din};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         div_step = {1'b1, diff[VoltW-1:0]};
      end else begin
         div_step = {1'b0, t[VoltW-1:0]};
      end
   endfunction

   for (genvar s = 0; s < DivStages; s++) begin : g_stage
      logic [VoltW-1:0] rem_src;
      logic [DutyW-1:0] low_src;
      logic [DutyW-1:0] quot_src;
      logic             valid_src;
      side_type         side_src;
      logic [VoltW-1:0] rem_in;
      logic [DutyW-1:0] low_in;
      logic [DutyW-1:0] quot_in;

      if (s == 0) begin : g_first
         assign rem_src   = in_dividend[ProdW-1:DutyW];
         assign low_src   = in_dividend[DutyW-1:0];
         assign quot_src  = '0;
         assign valid_src = in_valid;
         assign side_src  = in_side;
      end else begin : g_next
         assign rem_src   = rem_ff[s-1];
         assign low_src   = low_ff[s-1];
         assign quot_src  = quot_ff[s-1];
         assign valid_src = valid_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      always_comb begin
         logic [VoltW:0] st;
         rem_in  = rem_src;
         low_in  = low_src;
         quot_in = quot_src;
         for (int j = 0; j < BitsPerStage; j++) begin
            st      = div_step(rem_in, low_in[DutyW-1], divisor);
            quot_in = {quot_in[DutyW-2:0], st[VoltW]};
            rem_in  = st[VoltW-1:0];
            low_in  = {low_in[DutyW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
         rem_ff[s]  <= rem_in;
         low_ff[s]  <= low_in;
         quot_ff[s] <= quot_in;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid = valid_ff[DivStages-1];
   assign out_quot  = quot_ff[DivStages-1];
   assign out_side  = side_ff[DivStages-1];

endmodule

// ----- hdl/hbridge_voltage_to_pwm_top.sv -----
// ----------------------------------------------------------------------------
// H-bridge voltage to PWM drive
// The command passes the s0, s1, s2 and eight divider stages before the registered strobe.
// Throughput: one command per cycle; busy is never raised and the receiver cannot stall.
// Most of the depth is the divider, two quotient bits per stage over eight stages.
// Reset restores the default registers and empties the pipeline at once.
// ----------------------------------------------------------------------------
module hbridge_voltage_to_pwm_top
   import hbv2p_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic signed [CmdW-1:0]  req_volt_cmd_mv,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_index,
   input  logic [DutyW-1:0]        csr_wdata,
   output logic                    rsp_strobe,
   output logic                    rsp_dir_a,
   output logic                    rsp_dir_b,
   output logic [DutyW-1:0]        rsp_compare_a,
   output logic [DutyW-1:0]        rsp_compare_b
);

   logic             mode_ff;
   logic [VoltW-1:0] max_ff;
   logic [VoltW-1:0] min_ff;
   logic [DutyW-1:0] pwm_ff;

   logic                   s0_valid_ff;
   logic signed [CmdW-1:0] s0_cmd_ff;

   logic             s1_valid_ff;
   logic [VoltW-1:0] s1_mag_ff;
   logic [VoltW-1:0] s1_mag_in;
   side_type         s1_side_ff;
   side_type         s1_side_in;

   logic             s2_valid_ff;
   logic [ProdW-1:0] s2_prod_ff;
   side_type         s2_side_ff;

   logic             div_valid;
   logic [DutyW-1:0] div_quot;
   side_type         div_side;

   logic signed [CmdW:0] cmd_x;
   logic signed [CmdW:0] vmax_x;
   logic signed [CmdW:0] vmin_x;
   logic signed [CmdW:0] clamped;
   logic signed [CmdW:0] abs_val;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         max_ff  <= MaxVoltReset;
         min_ff  <= MinVoltReset;
         pwm_ff  <= PwmFullReset;
      end else if (csr_wr_en) begin
         case (csr_index)
            RegMode: mode_ff <= csr_wdata[0];
            RegMax:  max_ff  <= csr_wdata[VoltW-1:0];
            RegMin:  min_ff  <= csr_wdata[VoltW-1:0];
            RegPwm:  pwm_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= start & ~busy;
      end
      s0_cmd_ff <= req_volt_cmd_mv;
   end

   // Clamp to the saturation voltage and decide the pins and channel routing.
   always_comb begin
      cmd_x  = {s0_cmd_ff[CmdW-1], s0_cmd_ff};
      vmax_x = $signed({2'b00, max_ff});
      vmin_x = $signed({2'b00, min_ff});
      clamped = cmd_x;
      if (cmd_x > vmax_x) begin
         clamped = vmax_x;
      end else if (cmd_x < -vmax_x) begin
         clamped = -vmax_x;
      end
      abs_val   = (clamped < 0) ? -clamped : clamped;
      s1_mag_in = abs_val[VoltW-1:0];
      if (!mode_ff) begin
         s1_side_in.dir_a = (cmd_x > vmin_x);
         s1_side_in.dir_b = ~(cmd_x > vmin_x) & (cmd_x < -vmin_x);
         s1_side_in.sel_a = (max_ff != '0);
         s1_side_in.sel_b = 1'b0;
      end else begin
         s1_side_in.dir_a = 1'b0;
         s1_side_in.dir_b = 1'b0;
         s1_side_in.sel_a = (max_ff != '0) & (clamped > vmin_x);
         s1_side_in.sel_b = (max_ff != '0) & (clamped < -vmin_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_mag_ff  <= s1_mag_in;
      s1_side_ff <= s1_side_in;
      s2_prod_ff <= ProdW'(s1_mag_ff * pwm_ff);
      s2_side_ff <= s1_side_ff;
   end

   hbv2p_div u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid_ff),
      .in_dividend (s2_prod_ff),
      .divisor     (max_ff),
      .in_side     (s2_side_ff),
      .out_valid   (div_valid),
      .out_quot    (div_quot),
      .out_side    (div_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= div_valid;
      end
      rsp_dir_a     <= div_side.dir_a;
      rsp_dir_b     <= div_side.dir_b;
      rsp_compare_a <= div_side.sel_a ? div_quot : '0;
      rsp_compare_b <= div_side.sel_b ? div_quot : '0;
   end

endmodule

// ----- test/hbridge_voltage_to_pwm_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// H-bridge voltage to PWM drive testbench
// Sends signed voltage commands to the drive block and checks each returned beat
// against a table entry or a predictor, which clamps the command, scales it to a
// duty and routes it by drive mode and deadband. A table of directed commands and
// register writes comes first. Random commands under random register
// settings follow, with the command side idling at several rates.
// ----------------------------------------------------------------------------
module hbridge_voltage_to_pwm_top_tb
   import hbv2p_pkg::*;
();

   localparam int ItemsPerPhase = 450;
   localparam int CycleLimit    = 200000;
   localparam int DrainCycles   = 20;

   typedef struct packed {
      logic             dir_a;
      logic             dir_b;
      logic [DutyW-1:0] compare_a;
      logic [DutyW-1:0] compare_b;
   } bridge_drive_type;

   typedef enum logic {RowCommand, RowWrite} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [1:0]         index;
      logic [DutyW-1:0]   data;
      logic signed [15:0] cmd;
      bit                 typed;
      bridge_drive_type   drive;
   } directed_row_type;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic signed [CmdW-1:0]  req_volt_cmd_mv;
   logic                    csr_wr_en;
   logic [1:0]              csr_index;
   logic [DutyW-1:0]        csr_wdata;
   logic                    rsp_strobe;
   logic                    rsp_dir_a;
   logic                    rsp_dir_b;
   logic [DutyW-1:0]        rsp_compare_a;
   logic [DutyW-1:0]        rsp_compare_b;

   logic                    cfg_mode;
   logic [VoltW-1:0]        cfg_max_mv;
   logic [VoltW-1:0]        cfg_min_mv;
   logic [DutyW-1:0]        cfg_pwm_fs;

   bridge_drive_type        next_drive;
   bridge_drive_type        drive_expected_q[$];
   directed_row_type        directed_rows[$];
   int                      mismatch_count = 0;
   int                      cycle_count = 0;
   int                      gap_pct = 0;

   hbridge_voltage_to_pwm_top dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_volt_cmd_mv (req_volt_cmd_mv),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_dir_a       (rsp_dir_a),
      .rsp_dir_b       (rsp_dir_b),
      .rsp_compare_a   (rsp_compare_a),
      .rsp_compare_b   (rsp_compare_b)
   );

   always #5 clock = ~clock;

   function automatic bridge_drive_type predict_drive(input logic signed [15:0] cmd);
      int               vcmd;
      int               vmax;
      int               vmin;
      int               clamped;
      int               mag;
      longint           duty;
      bridge_drive_type r;
      vcmd = int'(cmd);
      vmax = int'(cfg_max_mv);
      vmin = int'(cfg_min_mv);
      clamped = vcmd;
      if (clamped > vmax) clamped = vmax;
      if (clamped < -vmax) clamped = -vmax;
      mag = (clamped < 0) ? -clamped : clamped;
      duty = 0;
      if (cfg_max_mv != '0) begin
         duty = (longint'(mag) * longint'(cfg_pwm_fs)) / longint'(cfg_max_mv);
      end
      r = '0;
      if (cfg_mode == 1'b0) begin
         if (vcmd > vmin) begin
            r.dir_a = 1'b1;
         end else if (vcmd < -vmin) begin
            r.dir_b = 1'b1;
         end
         r.compare_a = duty[15:0];
      end else begin
         if (clamped > vmin) begin
            r.compare_a = duty[15:0];
         end else if (clamped < -vmin) begin
            r.compare_b = duty[15:0];
         end
      end
      return r;
   endfunction

   function automatic logic signed [15:0] pick_command();
      int v;
      case ($urandom_range(7))
         0, 1: v = int'($urandom_range(65535));
         2: v = int'(cfg_max_mv) + int'($urandom_range(4)) - 2;
         3: v = int'(cfg_min_mv) + int'($urandom_range(4)) - 2;
         4: begin
            case ($urandom_range(4))
               0: v = 32767;
               1: v = -32768;
               2: v = 0;
               3: v = 1;
               default: v = -1;
            endcase
         end
         default: v = int'($urandom_range(int'(cfg_max_mv)));
      endcase
      if ($urandom_range(1) == 1) v = -v;
      return v[15:0];
   endfunction

   task automatic add_command(input logic signed [15:0] cmd);
      directed_row_type row;
      row = '{RowCommand, RegMode, '0, cmd, 1'b0, '0};
      directed_rows.push_back(row);
   endtask

   task automatic add_checked(input logic signed [15:0] cmd, input logic da,
                              input logic db, input logic [15:0] ca,
                              input logic [15:0] cb);
      directed_row_type row;
      row = '{RowCommand, RegMode, '0, cmd, 1'b1, '{da, db, ca, cb}};
      directed_rows.push_back(row);
   endtask

   task automatic add_write(input logic [1:0] index, input logic [15:0] data);
      directed_row_type row;
      row = '{RowWrite, index, data, '0, 1'b0, '0};
      directed_rows.push_back(row);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (drive_expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         RegMode: cfg_mode = data[0];
         RegMax:  cfg_max_mv = data[VoltW-1:0];
         RegMin:  cfg_min_mv = data[VoltW-1:0];
         RegPwm:  cfg_pwm_fs = data;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_command(input logic signed [15:0] cmd,
                               input bridge_drive_type drive);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         req_volt_cmd_mv <= CmdW'($urandom_range(65535));
         @(negedge clock);
      end
      start <= 1'b1;
      req_volt_cmd_mv <= cmd;
      next_drive <= drive;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic randomize_config();
      logic [VoltW-1:0] max_mv;
      logic [VoltW-1:0] min_mv;
      logic [DutyW-1:0] pwm_fs;
      case ($urandom_range(5))
         0: max_mv = 15'd1;
         1: max_mv = 15'd32767;
         2: max_mv = 15'd0;
         3: max_mv = VoltW'($urandom_range(1, 100));
         default: max_mv = VoltW'($urandom_range(1, 32767));
      endcase
      case ($urandom_range(3))
         0: min_mv = 15'd0;
         1: min_mv = 15'd32767;
         2: min_mv = VoltW'($urandom_range(0, 200));
         default: min_mv = VoltW'($urandom_range(0, 32767));
      endcase
      case ($urandom_range(3))
         0: pwm_fs = 16'd0;
         1: pwm_fs = 16'hFFFF;
         default: pwm_fs = DutyW'($urandom_range(65535));
      endcase
      write_reg(RegMode, {15'($urandom_range(32767)), 1'($urandom_range(1))});
      write_reg(RegMax, {1'($urandom_range(1)), max_mv});
      write_reg(RegMin, {1'($urandom_range(1)), min_mv});
      write_reg(RegPwm, pwm_fs);
   endtask

   always @(posedge clock) begin
      bridge_drive_type want;
      bridge_drive_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end else begin
         if (rsp_strobe === 1'b1) begin
            got = '{rsp_dir_a, rsp_dir_b, rsp_compare_a, rsp_compare_b};
            if (drive_expected_q.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10) begin
                  $display("Unexpected beat: dir_a %b dir_b %b cmp_a %0d cmp_b %0d",
                           got.dir_a, got.dir_b, got.compare_a, got.compare_b);
               end
            end else begin
               want = drive_expected_q.pop_front();
               if (got.dir_a !== want.dir_a || got.dir_b !== want.dir_b ||
                   got.compare_a !== want.compare_a ||
                   got.compare_b !== want.compare_b) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10) begin
                     $display("Mismatch: expected dir %b%b cmp %0d/%0d, got dir %b%b cmp %0d/%0d",
                              want.dir_a, want.dir_b, want.compare_a, want.compare_b,
                              got.dir_a, got.dir_b, got.compare_a, got.compare_b);
                  end
               end
            end
         end
         if (start === 1'b1 && busy === 1'b0 && reset === 1'b0) begin
            drive_expected_q.push_back(next_drive);
         end
      end
   end

   initial begin : stimulus
      int                 left;
      bridge_drive_type   drive;
      logic signed [15:0] cmd;
      reset = 1'b1;
      start = 1'b0;
      req_volt_cmd_mv = '0;
      csr_wr_en = 1'b0;
      csr_index = RegMode;
      csr_wdata = '0;
      next_drive = '0;
      cfg_mode = 1'b0;
      cfg_max_mv = MaxVoltReset;
      cfg_min_mv = MinVoltReset;
      cfg_pwm_fs = PwmFullReset;

      add_checked(16'sd0, 1'b0, 1'b0, 16'd0, 16'd0);
      add_checked(16'sd32767, 1'b1, 1'b0, 16'd1000, 16'd0);
      add_checked(-16'sd32768, 1'b0, 1'b1, 16'd1000, 16'd0);
      add_checked(16'sd11500, 1'b1, 1'b0, 16'd1000, 16'd0);
      add_command(16'sd50);
      add_command(16'sd51);
      add_command(-16'sd51);
      add_command(-16'sd50);
      add_checked(16'sh5555, 1'b1, 1'b0, 16'd1000, 16'd0);
      add_checked(16'shAAAA, 1'b0, 1'b1, 16'd1000, 16'd0);
      add_write(RegMode, 16'd1);
      add_checked(16'sd32767, 1'b0, 1'b0, 16'd1000, 16'd0);
      add_checked(-16'sd32768, 1'b0, 1'b0, 16'd0, 16'd1000);
      add_checked(16'sd50, 1'b0, 1'b0, 16'd0, 16'd0);
      add_command(-16'sd2000);
      // The deadband is wider than the saturation voltage until that voltage is next raised.
      add_write(RegMin, 16'd20000);
      add_checked(16'sd32767, 1'b0, 1'b0, 16'd0, 16'd0);
      add_write(RegMode, 16'hFFFE);
      add_checked(16'sd32767, 1'b1, 1'b0, 16'd1000, 16'd0);
      add_checked(16'sd15000, 1'b0, 1'b0, 16'd1000, 16'd0);
      // A zero saturation voltage gives a zero duty on both channels.
      add_write(RegMax, 16'd0);
      add_checked(16'sd1234, 1'b0, 1'b0, 16'd0, 16'd0);
      add_checked(-16'sd32768, 1'b0, 1'b1, 16'd0, 16'd0);
      add_write(RegMax, 16'hFFFF);
      add_write(RegPwm, 16'hFFFF);
      add_write(RegMin, 16'h8000);
      add_checked(16'sd32767, 1'b1, 1'b0, 16'hFFFF, 16'd0);
      add_checked(-16'sd32768, 1'b0, 1'b1, 16'hFFFF, 16'd0);
      add_command(16'sd1);
      add_write(RegPwm, 16'd0);
      add_checked(16'sd1000, 1'b1, 1'b0, 16'd0, 16'd0);
      add_checked(16'sd0, 1'b0, 1'b0, 16'd0, 16'd0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      gap_pct = 22;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowWrite) begin
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            drive = directed_rows[i].typed ? directed_rows[i].drive
                                           : predict_drive(directed_rows[i].cmd);
            send_command(directed_rows[i].cmd, drive);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 22 : (phase == 1) ? 45 : 0;
         left = 0;
         for (int n = 0; n < ItemsPerPhase; n++) begin
            if (left == 0) begin
               randomize_config();
               left = $urandom_range(30, 70);
            end
            cmd = pick_command();
            send_command(cmd, predict_drive(cmd));
            left--;
         end
      end

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && drive_expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- hbridge_voltage_to_pwm_top.f -----
hdl/hbv2p_pkg.sv
hdl/hbv2p_div.sv
hdl/hbridge_voltage_to_pwm_top.sv
test/hbridge_voltage_to_pwm_top_tb.sv
